// ----- hw/rtl/command_line_continuation_joiner_defines.svh -----
// Assertion macros used by the checker file of the command line joiner.
`ifndef COMMAND_LINE_CONTINUATION_JOINER_DEFINES_SVH
`define COMMAND_LINE_CONTINUATION_JOINER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CCLJ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CCLJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cclj_pkg.sv -----
// Types and constants of the command line joiner.
`default_nettype none

package cclj_pkg;

  localparam int unsigned CAP_W   = 12;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned CNT_W   = 6;  // blank run count, covers the full BLANK_RUN range
  localparam int unsigned ADDR_W  = 6;  // blank store address, covers the full BLANK_RUN range

  localparam logic [CAP_W-1:0] CAP_RESET = 12'd1024;
  localparam logic [LEN_W-1:0] LEN_MAX   = 13'd8191;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_CONT      = 2'd1,
    ST_CMD_OVF   = 2'd2,
    ST_BLANK_OVF = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PRE,
    BK_BLANK,
    BK_ENDC,
    BK_STAT
  } back_state_e;

  // One queued job: everything an input item emits, in emission order.
  typedef struct packed {
    logic             pre_v;
    logic [7:0]       pre_char;
    logic [CNT_W-1:0] nblank;
    logic             end_v;
    logic [7:0]       end_char;
    logic             stat_v;
    status_e          status;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic              data;  // 1 = tab
  } blk_wr_t;

  typedef struct packed {
    logic blk_done;  // a job that read the blank store has finished
  } back_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cclj_if.sv -----
// Input and output channel interfaces of the command line joiner.
`default_nettype none

interface cclj_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       has_char;
  logic       line_end;
  logic       quote_at_start;

  modport source (output valid, in_char, has_char, line_end, quote_at_start, input ready);
  modport sink   (input valid, in_char, has_char, line_end, quote_at_start, output ready);
endinterface

interface cclj_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_char;
  logic [1:0] line_status;
  logic       last_of_run;

  modport source (output valid, kind, out_char, line_status, last_of_run, input ready);
  modport sink   (input valid, kind, out_char, line_status, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cclj_queue.sv -----
// Two-entry job queue between the front and back parts.
`default_nettype none

module cclj_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cclj_pkg::job_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output cclj_pkg::job_t  pop_data_o,
  output logic            empty_o
);

  cclj_pkg::job_t ent_q [2];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = ent_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cclj_front.sv -----
// Front part: takes characters, tracks line state, queues emission jobs.
`default_nettype none

module cclj_front #(
  parameter int unsigned BLANK_RUN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cclj_in_if.sink                       in_i,
  input  logic                          cfg_we_i,
  input  logic [cclj_pkg::CAP_W-1:0]    cfg_wdata_i,
  output logic                          push_o,
  output cclj_pkg::job_t                job_o,
  input  logic                          full_i,
  output cclj_pkg::blk_wr_t             wr_o,
  input  cclj_pkg::back_stat_t          bstat_i
);

  localparam int unsigned CW  = $clog2(BLANK_RUN + 2);
  localparam int unsigned LSW = cclj_pkg::LEN_W + 1;
  localparam logic [CW-1:0] RUN_MAX = CW'(BLANK_RUN);
  localparam logic [CW-1:0] RUN_OVF = CW'(BLANK_RUN + 1);

  logic [cclj_pkg::CAP_W-1:0] cap_q;
  logic quote_q, quote_d;
  logic comment_q, comment_d;
  logic null_q, null_d;
  logic start_q, start_d;
  logic [7:0] held_q, held_d;
  logic held_v_q, held_v_d;
  logic [CW-1:0] bcnt_q, bcnt_d;
  logic bovf_q, bovf_d;
  logic [cclj_pkg::LEN_W-1:0] llen_q, llen_d;
  logic [cclj_pkg::LEN_W-1:0] clen_q, clen_d;
  logic pend_q, pend_d;  // a blank-reading job is queued or running

  logic acc;
  logic [7:0] c;
  logic [CW-1:0] stored;
  logic [LSW-1:0] lsum;
  logic [LSW-1:0] csum;
  logic cont;
  cclj_pkg::status_e st;

  assign c         = in_i.in_char;
  assign in_i.ready = !full_i && !pend_q;
  assign acc       = in_i.valid && in_i.ready;

  always_comb begin
    quote_d   = quote_q;
    comment_d = comment_q;
    null_d    = null_q;
    start_d   = start_q;
    held_d    = held_q;
    held_v_d  = held_v_q;
    bcnt_d    = bcnt_q;
    bovf_d    = bovf_q;
    llen_d    = llen_q;
    clen_d    = clen_q;
    job_o     = '0;
    wr_o      = '0;
    stored    = '0;
    lsum      = '0;
    csum      = '0;
    cont      = 1'b0;
    st        = cclj_pkg::ST_DONE;

    if (acc && (in_i.has_char || in_i.line_end)) begin
      start_d = 1'b0;
      if (start_q) begin
        quote_d = in_i.quote_at_start;
        if (in_i.has_char && c == cclj_pkg::CH_HASH && clen_q == '0) begin
          null_d = 1'b1;
        end
      end

      if (in_i.has_char && !null_d && !comment_d) begin
        if (!quote_d && c == cclj_pkg::CH_BANG) begin
          comment_d = 1'b1;
        end else begin
          if (c == cclj_pkg::CH_QUOTE) begin
            quote_d = ~quote_d;
          end
          if (c == cclj_pkg::CH_SPACE || c == cclj_pkg::CH_TAB) begin
            if (bcnt_q < RUN_MAX) begin
              wr_o.we   = 1'b1;
              wr_o.addr = cclj_pkg::ADDR_W'(bcnt_q);
              wr_o.data = (c == cclj_pkg::CH_TAB);
              bcnt_d    = bcnt_q + 1'b1;
            end else begin
              bcnt_d = RUN_OVF;
            end
          end else begin
            // non-blank: release held char and the blank run behind it
            job_o.pre_v    = held_v_q;
            job_o.pre_char = held_q;
            if (bcnt_q > RUN_MAX) begin
              stored = RUN_MAX;
              bovf_d = 1'b1;
            end else begin
              stored = bcnt_q;
            end
            job_o.nblank = cclj_pkg::CNT_W'(stored);
            lsum   = {1'b0, llen_q} + LSW'(stored) + LSW'(1);
            llen_d = (lsum > LSW'(cclj_pkg::LEN_MAX)) ? cclj_pkg::LEN_MAX
                                                     : lsum[cclj_pkg::LEN_W-1:0];
            bcnt_d   = '0;
            held_d   = c;
            held_v_d = 1'b1;
          end
        end
      end

      if (in_i.line_end) begin
        csum = {1'b0, llen_d} + {1'b0, clen_q};
        if (null_d) begin
          st = cclj_pkg::ST_DONE;
        end else begin
          if (held_v_d) begin
            cont           = (held_d == cclj_pkg::CH_PLUS);
            job_o.end_v    = 1'b1;
            job_o.end_char = cont ? cclj_pkg::CH_SPACE : held_d;
          end
          priority if (bovf_d) begin
            st = cclj_pkg::ST_BLANK_OVF;
          end else if (csum > LSW'(cap_q)) begin
            st = cclj_pkg::ST_CMD_OVF;
          end else if (cont) begin
            st = cclj_pkg::ST_CONT;
          end else begin
            st = cclj_pkg::ST_DONE;
          end
        end
        clen_d       = (st == cclj_pkg::ST_CONT) ? csum[cclj_pkg::LEN_W-1:0] : '0;
        job_o.stat_v = 1'b1;
        job_o.status = st;
        comment_d = 1'b0;
        null_d    = 1'b0;
        start_d   = 1'b1;
        held_d    = '0;
        held_v_d  = 1'b0;
        bcnt_d    = '0;
        bovf_d    = 1'b0;
        llen_d    = '0;
      end
    end

    push_o = acc && (job_o.pre_v || job_o.nblank != '0 || job_o.end_v || job_o.stat_v);

    pend_d = pend_q;
    if (push_o && job_o.nblank != '0) begin
      pend_d = 1'b1;
    end else if (bstat_i.blk_done) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= cclj_pkg::CAP_RESET;
      quote_q   <= 1'b0;
      comment_q <= 1'b0;
      null_q    <= 1'b0;
      start_q   <= 1'b1;
      held_q    <= '0;
      held_v_q  <= 1'b0;
      bcnt_q    <= '0;
      bovf_q    <= 1'b0;
      llen_q    <= '0;
      clen_q    <= '0;
      pend_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      quote_q   <= quote_d;
      comment_q <= comment_d;
      null_q    <= null_d;
      start_q   <= start_d;
      held_q    <= held_d;
      held_v_q  <= held_v_d;
      bcnt_q    <= bcnt_d;
      bovf_q    <= bovf_d;
      llen_q    <= llen_d;
      clen_q    <= clen_d;
      pend_q    <= pend_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cclj_back.sv -----
// Back part: blank store and result sequencer, one result per transfer.
`default_nettype none

module cclj_back #(
  parameter int unsigned BLANK_RUN = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  cclj_pkg::job_t        job_i,
  output logic                  pop_o,
  input  cclj_pkg::blk_wr_t     wr_i,
  output cclj_pkg::back_stat_t  bstat_o,
  cclj_out_if.source            out_o
);

  localparam int unsigned CW = $clog2(BLANK_RUN + 2);
  localparam int unsigned IW = $clog2(BLANK_RUN);
  localparam int unsigned XW = cclj_pkg::CNT_W + 1;

  logic                    mem [BLANK_RUN];
  logic                    rd_q;
  logic [IW-1:0]           raddr;

  cclj_pkg::back_state_e   state_q, state_d, after, first, tail;
  cclj_pkg::job_t          job_q, job_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic                    fire;

  assign fire = out_o.valid && out_o.ready;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;

    tail = job_q.end_v ? cclj_pkg::BK_ENDC
         : (job_q.stat_v ? cclj_pkg::BK_STAT : cclj_pkg::BK_IDLE);

    if (job_i.pre_v) begin
      first = cclj_pkg::BK_PRE;
    end else if (job_i.nblank != '0) begin
      first = cclj_pkg::BK_BLANK;
    end else if (job_i.end_v) begin
      first = cclj_pkg::BK_ENDC;
    end else begin
      first = cclj_pkg::BK_STAT;
    end

    unique case (state_q)
      cclj_pkg::BK_IDLE:  after = cclj_pkg::BK_IDLE;
      cclj_pkg::BK_PRE:   after = (job_q.nblank != '0) ? cclj_pkg::BK_BLANK : tail;
      cclj_pkg::BK_BLANK: after = (XW'(idx_q) + XW'(1) < XW'(job_q.nblank))
                                  ? cclj_pkg::BK_BLANK : tail;
      cclj_pkg::BK_ENDC:  after = job_q.stat_v ? cclj_pkg::BK_STAT : cclj_pkg::BK_IDLE;
      cclj_pkg::BK_STAT:  after = cclj_pkg::BK_IDLE;
      default:            after = cclj_pkg::BK_IDLE;
    endcase

    if (state_q == cclj_pkg::BK_IDLE) begin
      if (!empty_i) begin
        pop_o   = 1'b1;
        job_d   = job_i;
        idx_d   = '0;
        state_d = first;
      end
    end else if (fire) begin
      state_d = after;
      if (state_q == cclj_pkg::BK_BLANK) begin
        idx_d = idx_q + 1'b1;
      end
    end

    // read the blank the next cycle will show
    raddr = (idx_d < CW'(BLANK_RUN)) ? idx_d[IW-1:0] : '0;

    bstat_o.blk_done = fire && (after == cclj_pkg::BK_IDLE) && (job_q.nblank != '0);

    out_o.valid       = (state_q != cclj_pkg::BK_IDLE);
    out_o.kind        = (state_q == cclj_pkg::BK_STAT) ? cclj_pkg::KIND_STATUS
                                                       : cclj_pkg::KIND_CHAR;
    out_o.line_status = (state_q == cclj_pkg::BK_STAT) ? job_q.status : cclj_pkg::ST_DONE;
    out_o.last_of_run = (after == cclj_pkg::BK_IDLE);
    unique case (state_q)
      cclj_pkg::BK_PRE:   out_o.out_char = job_q.pre_char;
      cclj_pkg::BK_BLANK: out_o.out_char = rd_q ? cclj_pkg::CH_TAB : cclj_pkg::CH_SPACE;
      cclj_pkg::BK_ENDC:  out_o.out_char = job_q.end_char;
      default:            out_o.out_char = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cclj_pkg::BK_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr[IW-1:0]] <= wr_i.data;
    end
    rd_q <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/command_line_continuation_joiner.sv -----
// Command line joiner top level: front classifier, job queue, back sequencer.
//
// Takes one character per input transfer and emits the cleaned command text,
// one result per output transfer, then a status result at each line end
// (complete, continue, command overflow, blank run overflow). Unquoted '!'
// starts a dropped comment, '"' toggles quoting, trailing blanks are stripped
// by holding back the last non-blank and the blank run after it, a final '+'
// becomes a blank and means continue, and a leading '#' on an empty command
// makes a null line. A blank, comment or otherwise silent item queues no
// job; an item that emits results is popped by the back sequencer from idle,
// which then gives one result per cycle while the output is ready. The front
// takes items while the two-entry job queue has room, except that once a job
// reading the blank run store is queued it holds off until that job's last
// result has been transferred and a registered pending flag has cleared, since
// the store has one write and one read port. The blank store needs no
// clearing pass.
`default_nettype none

module command_line_continuation_joiner #(
  parameter int unsigned BLANK_RUN = 32  // stored blanks per run, 2..61
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cclj_pkg::CAP_W-1:0]  cfg_wdata_i,  // command_capacity
  cclj_in_if.sink                     in_i,
  cclj_out_if.source                  out_o
);

  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  empty;
  cclj_pkg::job_t        push_job;
  cclj_pkg::job_t        pop_job;
  cclj_pkg::blk_wr_t     blk_wr;
  cclj_pkg::back_stat_t  bstat;

  // front: line state, capacity register, blank store writes
  cclj_front #(.BLANK_RUN(BLANK_RUN)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push),
    .job_o       (push_job),
    .full_i      (full),
    .wr_o        (blk_wr),
    .bstat_i     (bstat)
  );

  // jobs in flight between the two sides
  cclj_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  // back: blank store and per-result output transfer
  cclj_back #(.BLANK_RUN(BLANK_RUN)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (pop_job),
    .pop_o   (pop),
    .wr_i    (blk_wr),
    .bstat_o (bstat),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/cclj_checker.sv -----
// Port-level assertions of the command line joiner and their bind.
`default_nettype none

`include "command_line_continuation_joiner_defines.svh"

module cclj_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_kind_i,
  input logic [7:0] out_char_i,
  input logic [1:0] out_status_i,
  input logic       out_last_i
);

  `CCLJ_ASSERT_NEXT(a_valid_holds, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `CCLJ_ASSERT_NEXT(a_payload_holds, out_valid_i && !out_ready_i, $stable(out_kind_i) && $stable(out_char_i) && $stable(out_status_i) && $stable(out_last_i), "result changed while stalled")
  `CCLJ_ASSERT_NOW(a_status_last, out_valid_i && out_kind_i == cclj_pkg::KIND_STATUS, out_last_i && out_char_i == 8'h00, "status result not last or has a char")
  `CCLJ_ASSERT_NOW(a_char_no_status, out_valid_i && out_kind_i == cclj_pkg::KIND_CHAR, out_status_i == 2'd0, "char result carries a status")

endmodule

bind command_line_continuation_joiner cclj_checker u_cclj_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_kind_i   (out_o.kind),
  .out_char_i   (out_o.out_char),
  .out_status_i (out_o.line_status),
  .out_last_i   (out_o.last_of_run)
);

`default_nettype wire
